// ===== hdl/s5hs_pkg.sv =====
// shared types and constants for the socks5 handshake parser
package s5hs_pkg;

  localparam int CredBytes = 16;

  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_BACKEND = 2'd1;
  localparam logic [1:0] ACT_NEW     = 2'd2;

  localparam logic [2:0] KIND_REPLY   = 3'd0;
  localparam logic [2:0] KIND_HOST    = 3'd1;
  localparam logic [2:0] KIND_DONE    = 3'd2;
  localparam logic [2:0] KIND_FWD     = 3'd3;
  localparam logic [2:0] KIND_CLOSED  = 3'd4;

  localparam logic [2:0] CFG_USER_LEN = 3'd0;
  localparam logic [2:0] CFG_USER_LO  = 3'd1;
  localparam logic [2:0] CFG_USER_HI  = 3'd2;
  localparam logic [2:0] CFG_PASS_LEN = 3'd3;
  localparam logic [2:0] CFG_PASS_LO  = 3'd4;
  localparam logic [2:0] CFG_PASS_HI  = 3'd5;

  // command codes passed from the parser to the reply emitter
  typedef enum logic [3:0] {
    CMD_METH_OK,    // 05 02
    CMD_METH_BAD,   // 05 ff close
    CMD_AUTH_OK,    // 01 00
    CMD_AUTH_BAD,   // 01 01 close
    CMD_LONG_CLOSE, // 05 code 00 01 0*6 close
    CMD_LONG_OPEN,  // 05 00 00 01 0*6
    CMD_CLOSE,      // close alone
    CMD_HOST,
    CMD_DONE,
    CMD_FWD
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  data;
    logic        dom;
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  hlen;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic        dom;
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  hlen;
    logic        last;
  } res_t;

  function automatic logic [7:0] cred_byte(logic [63:0] lo, logic [63:0] hi,
                                           logic [7:0] idx);
    logic [127:0] w;
    w = {hi, lo};
    if (idx >= 8'(CredBytes)) return 8'h00;
    return w[idx[3:0]*8 +: 8];
  endfunction

  function automatic logic cred_ok(logic [63:0] lo, logic [63:0] hi,
                                   logic [7:0] idx, logic [7:0] b);
    return (idx < 8'(CredBytes)) && (cred_byte(lo, hi, idx) == b);
  endfunction

endpackage

// ===== hdl/s5hs_front.sv =====
// front end: takes input beats, runs the handshake parser, issues commands
module s5hs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  input  logic                take_i,
  input  logic [1:0]          action_i,
  input  logic [7:0]          byte_value_i,
  input  logic                backend_ok_i,
  output logic                cmd_valid_o,
  output s5hs_pkg::cmd_t      cmd_o
);
  import s5hs_pkg::*;

  localparam logic [3:0] PH_GREET_VER = 4'd0;
  localparam logic [3:0] PH_GREET_N   = 4'd1;
  localparam logic [3:0] PH_METHODS   = 4'd2;
  localparam logic [3:0] PH_SUB_VER   = 4'd3;
  localparam logic [3:0] PH_ULEN      = 4'd4;
  localparam logic [3:0] PH_UNAME     = 4'd5;
  localparam logic [3:0] PH_PLEN      = 4'd6;
  localparam logic [3:0] PH_PASS      = 4'd7;
  localparam logic [3:0] PH_REQ       = 4'd8;
  localparam logic [3:0] PH_IPV4      = 4'd9;
  localparam logic [3:0] PH_DLEN      = 4'd10;
  localparam logic [3:0] PH_DOMAIN    = 4'd11;
  localparam logic [3:0] PH_PORT      = 4'd12;
  localparam logic [3:0] PH_WAIT      = 4'd13;
  localparam logic [3:0] PH_RELAY     = 4'd14;
  localparam logic [3:0] PH_CLOSED    = 4'd15;

  logic [4:0]  user_len_q, pass_len_q;
  logic [63:0] user_lo_q, user_hi_q, pass_lo_q, pass_hi_q;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  cnt_q, cnt_d, flen_q, flen_d;
  logic        offers_q, offers_d, um_q, um_d, pm_q, pm_d, dom_q, dom_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] port_q, port_d;
  logic        cv_d;
  cmd_t        c_d;
  logic [7:0]  b, cnt_inc;
  logic        verdict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_len_q <= '0; pass_len_q <= '0;
      user_lo_q <= '0; user_hi_q <= '0; pass_lo_q <= '0; pass_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_USER_LEN: user_len_q <= cfg_data_i[4:0];
        CFG_USER_LO:  user_lo_q  <= cfg_data_i;
        CFG_USER_HI:  user_hi_q  <= cfg_data_i;
        CFG_PASS_LEN: pass_len_q <= cfg_data_i[4:0];
        CFG_PASS_LO:  pass_lo_q  <= cfg_data_i;
        CFG_PASS_HI:  pass_hi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    b = byte_value_i;
    cnt_inc = cnt_q + 8'd1;
    phase_d = phase_q; cnt_d = cnt_q; flen_d = flen_q; offers_d = offers_q;
    um_d = um_q; pm_d = pm_q; dom_d = dom_q; addr_d = addr_q; port_d = port_q;
    cv_d = 1'b0;
    verdict = 1'b0;
    c_d = '0;
    c_d.cmd = CMD_CLOSE;
    if (take_i) begin
      if (action_i == ACT_BYTE) begin
        unique case (phase_q)
          PH_GREET_VER: begin
            if (b != 8'h05) begin cv_d = 1'b1; phase_d = PH_CLOSED; end
            else phase_d = PH_GREET_N;
          end
          PH_GREET_N: begin
            flen_d = b; cnt_d = '0; offers_d = 1'b0;
            if (b == 8'h00) begin
              cv_d = 1'b1; c_d.cmd = CMD_METH_BAD; phase_d = PH_CLOSED;
            end else phase_d = PH_METHODS;
          end
          PH_METHODS: begin
            offers_d = offers_q | (b == 8'h02);
            cnt_d = cnt_inc;
            if (cnt_inc == flen_q) begin
              cv_d = 1'b1;
              if (offers_d) begin c_d.cmd = CMD_METH_OK; phase_d = PH_SUB_VER; end
              else begin c_d.cmd = CMD_METH_BAD; phase_d = PH_CLOSED; end
            end
          end
          PH_SUB_VER: begin
            if (b != 8'h01) begin cv_d = 1'b1; phase_d = PH_CLOSED; end
            else phase_d = PH_ULEN;
          end
          PH_ULEN: begin
            flen_d = b; cnt_d = '0; um_d = (b == {3'b0, user_len_q});
            phase_d = (b == 8'h00) ? PH_PLEN : PH_UNAME;
          end
          PH_UNAME: begin
            if (!cred_ok(user_lo_q, user_hi_q, cnt_q, b)) um_d = 1'b0;
            cnt_d = cnt_inc;
            if (cnt_inc == flen_q) phase_d = PH_PLEN;
          end
          PH_PLEN: begin
            flen_d = b; cnt_d = '0; pm_d = (b == {3'b0, pass_len_q});
            if (b != 8'h00) phase_d = PH_PASS;
            else verdict = 1'b1;
          end
          PH_PASS: begin
            if (!cred_ok(pass_lo_q, pass_hi_q, cnt_q, b)) pm_d = 1'b0;
            cnt_d = cnt_inc;
            if (cnt_inc == flen_q) verdict = 1'b1;
          end
          PH_REQ: begin
            if (cnt_q < 8'd3) begin
              addr_d = {addr_q[23:0], b}; cnt_d = cnt_inc;
            end else if (addr_q[23:16] != 8'h05 || addr_q[15:8] != 8'h01) begin
              cv_d = 1'b1; c_d.cmd = CMD_LONG_CLOSE; c_d.data = 8'h07;
              phase_d = PH_CLOSED;
            end else begin
              addr_d = '0; port_d = '0; cnt_d = '0;
              if (b == 8'h01) begin dom_d = 1'b0; phase_d = PH_IPV4; end
              else if (b == 8'h03) begin dom_d = 1'b1; phase_d = PH_DLEN; end
              else begin
                cv_d = 1'b1; c_d.cmd = CMD_LONG_CLOSE; c_d.data = 8'h08;
                phase_d = PH_CLOSED;
              end
            end
          end
          PH_IPV4: begin
            if (cnt_q < 8'd4) addr_d = {addr_q[23:0], b};
            else port_d = {port_q[7:0], b};
            cnt_d = cnt_inc;
            if (cnt_inc == 8'd6) begin
              cv_d = 1'b1; c_d.cmd = CMD_DONE; c_d.ip = addr_d;
              c_d.port = port_d; phase_d = PH_WAIT;
            end
          end
          PH_DLEN: begin
            flen_d = b; cnt_d = '0;
            phase_d = (b == 8'h00) ? PH_PORT : PH_DOMAIN;
          end
          PH_DOMAIN: begin
            cv_d = 1'b1; c_d.cmd = CMD_HOST; c_d.data = b;
            cnt_d = cnt_inc;
            if (cnt_inc == flen_q) begin cnt_d = '0; phase_d = PH_PORT; end
          end
          PH_PORT: begin
            port_d = {port_q[7:0], b}; cnt_d = cnt_inc;
            if (cnt_inc == 8'd2) begin
              cv_d = 1'b1; c_d.cmd = CMD_DONE; c_d.port = port_d;
              c_d.dom = dom_q; c_d.hlen = dom_q ? flen_q : 8'h00;
              c_d.ip = dom_q ? 32'h0 : addr_q;
              phase_d = PH_WAIT;
            end
          end
          PH_RELAY: begin
            cv_d = 1'b1; c_d.cmd = CMD_FWD; c_d.data = b;
          end
          default: ;
        endcase
        if (verdict) begin
          cv_d = 1'b1;
          if (um_d && pm_d) begin
            c_d.cmd = CMD_AUTH_OK; phase_d = PH_REQ; cnt_d = '0; addr_d = '0;
          end else begin
            c_d.cmd = CMD_AUTH_BAD; phase_d = PH_CLOSED;
          end
        end
      end else if (action_i == ACT_BACKEND) begin
        if (phase_q == PH_WAIT) begin
          cv_d = 1'b1;
          if (backend_ok_i) begin
            c_d.cmd = CMD_LONG_OPEN; c_d.data = 8'h00; phase_d = PH_RELAY;
          end else begin
            c_d.cmd = CMD_LONG_CLOSE; c_d.data = 8'h05; phase_d = PH_CLOSED;
          end
        end
      end else if (action_i == ACT_NEW) begin
        phase_d = PH_GREET_VER; cnt_d = '0; flen_d = '0; offers_d = 1'b0;
        um_d = 1'b0; pm_d = 1'b0; dom_d = 1'b0; addr_d = '0; port_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GREET_VER; cnt_q <= '0; flen_q <= '0; offers_q <= 1'b0;
      um_q <= 1'b0; pm_q <= 1'b0; dom_q <= 1'b0; addr_q <= '0; port_q <= '0;
      cmd_valid_o <= 1'b0;
    end else begin
      phase_q <= phase_d; cnt_q <= cnt_d; flen_q <= flen_d; offers_q <= offers_d;
      um_q <= um_d; pm_q <= pm_d; dom_q <= dom_d; addr_q <= addr_d;
      port_q <= port_d; cmd_valid_o <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_o <= c_d;
  end

  a_wait_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_WAIT) ##1 (phase_q == PH_WAIT) |-> cmd_valid_o)
    else $error("entered wait without request done");
  a_closed_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CLOSED) && !(take_i && action_i == ACT_NEW) |=> (phase_q == PH_CLOSED))
    else $error("left closed without new session");
  a_no_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_i |=> !cmd_valid_o)
    else $error("command without beat");
endmodule

// ===== hdl/s5hs_queue.sv =====
// short command queue between parser and emitter
module s5hs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  s5hs_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output logic           empty_o,
  output logic           almost_full_o,
  output s5hs_pkg::cmd_t head_o
);
  import s5hs_pkg::*;

  localparam int Depth = 4;

  cmd_t       mem_q [Depth];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  assign empty_o = (cnt_q == 3'd0);
  // room is kept for a command still in the front register
  assign almost_full_o = (cnt_q >= 3'd2);
  assign head_o = mem_q[rd_q];

  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_i && cnt_q == 3'(Depth)))
    else $error("queue overflow");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 3'd1)
    else $error("count slip");
endmodule

// ===== hdl/s5hs_back.sv =====
// back end: expands commands into result beats
module s5hs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  s5hs_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           stall_i,
  output s5hs_pkg::res_t res_o
);
  import s5hs_pkg::*;

  logic [3:0] idx_q;
  logic [3:0] nres;
  res_t       r;
  logic       fire;

  always_comb begin
    r = '0;
    nres = 4'd1;
    unique case (head_i.cmd)
      CMD_METH_OK, CMD_METH_BAD, CMD_AUTH_OK, CMD_AUTH_BAD: begin
        nres = (head_i.cmd == CMD_METH_BAD || head_i.cmd == CMD_AUTH_BAD) ? 4'd3 : 4'd2;
        r.kind = (idx_q == 4'd2) ? KIND_CLOSED : KIND_REPLY;
        if (idx_q == 4'd0)
          r.out_byte = (head_i.cmd == CMD_METH_OK || head_i.cmd == CMD_METH_BAD)
                       ? 8'h05 : 8'h01;
        else if (idx_q == 4'd1)
          unique case (head_i.cmd)
            CMD_METH_OK:  r.out_byte = 8'h02;
            CMD_METH_BAD: r.out_byte = 8'hFF;
            CMD_AUTH_OK:  r.out_byte = 8'h00;
            default:      r.out_byte = 8'h01;
          endcase
      end
      CMD_LONG_CLOSE, CMD_LONG_OPEN: begin
        nres = (head_i.cmd == CMD_LONG_CLOSE) ? 4'd11 : 4'd10;
        r.kind = (idx_q == 4'd10) ? KIND_CLOSED : KIND_REPLY;
        unique case (idx_q)
          4'd0:    r.out_byte = 8'h05;
          4'd1:    r.out_byte = head_i.data;
          4'd3:    r.out_byte = 8'h01;
          default: r.out_byte = 8'h00;
        endcase
      end
      CMD_CLOSE: r.kind = KIND_CLOSED;
      CMD_HOST: begin r.kind = KIND_HOST; r.out_byte = head_i.data; end
      CMD_FWD:  begin r.kind = KIND_FWD;  r.out_byte = head_i.data; end
      CMD_DONE: begin
        r.kind = KIND_DONE; r.dom = head_i.dom; r.ip = head_i.ip;
        r.port = head_i.port; r.hlen = head_i.hlen;
      end
      default: ;
    endcase
    r.last = (idx_q == nres - 4'd1);
  end

  assign fire  = !empty_i && (!valid_o || !stall_i);
  assign pop_o = fire && r.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; valid_o <= 1'b0;
    end else begin
      if (fire) idx_q <= r.last ? 4'd0 : idx_q + 4'd1;
      if (fire) valid_o <= 1'b1;
      else if (!stall_i) valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_o <= r;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(res_o))
    else $error("stalled beat changed");
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 4'd10)
    else $error("index out of range");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 4'd0)
    else $error("index not cleared");
endmodule

// ===== hdl/socks5_server_handshake_parser.sv =====
// top level of the socks5 server handshake parser
//
//  channel  | valid     | stall     | payload
//  input    | in_valid  | in_stall  | action, byte_value, backend_ok
//  output   | out_valid | out_stall | kind, out_byte, target_*, host_length, last
//  config   | cfg_we    | -         | cfg_index, cfg_data
//
// one input beat per cycle unless in_stall is high; the parser queues at most one command per beat.
// a command expands into 1 to 11 result beats, one per cycle at the output register while out_stall is low.
// input stalls while the four-entry command queue holds two or more commands.
// asynchronous active-low reset clears phase, queue and output valid.
module socks5_server_handshake_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  byte_value_i,
  input  logic        backend_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic        target_is_domain_o,
  output logic [31:0] target_ipv4_o,
  output logic [15:0] target_port_o,
  output logic [7:0]  host_length_o,
  output logic        last_o
);
  import s5hs_pkg::*;

  logic cmd_valid, empty, afull, pop, take;
  cmd_t cmd, head;
  res_t res;

  assign in_stall_o = afull;
  assign take = in_valid_i && !afull;

  s5hs_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .take_i(take), .action_i, .byte_value_i, .backend_ok_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd)
  );

  s5hs_queue u_queue (
    .clk_i, .rst_ni, .push_i(cmd_valid), .push_data_i(cmd), .pop_i(pop),
    .empty_o(empty), .almost_full_o(afull), .head_o(head)
  );

  s5hs_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop),
    .valid_o(out_valid_o), .stall_i(out_stall_i), .res_o(res)
  );

  assign kind_o             = res.kind;
  assign out_byte_o         = res.out_byte;
  assign target_is_domain_o = res.dom;
  assign target_ipv4_o      = res.ip;
  assign target_port_o      = res.port;
  assign host_length_o      = res.hlen;
  assign last_o             = res.last;
endmodule

// ===== sim/tb_socks5_server_handshake_parser.sv =====
// self-checking testbench for the socks5 server handshake parser
`timescale 1ns / 1ps

module tb_socks5_server_handshake_parser;
  import s5hs_pkg::*;

  localparam logic [3:0] PH_GREET_VER = 4'd0;
  localparam logic [3:0] PH_GREET_N   = 4'd1;
  localparam logic [3:0] PH_METHODS   = 4'd2;
  localparam logic [3:0] PH_SUB_VER   = 4'd3;
  localparam logic [3:0] PH_ULEN      = 4'd4;
  localparam logic [3:0] PH_UNAME     = 4'd5;
  localparam logic [3:0] PH_PLEN      = 4'd6;
  localparam logic [3:0] PH_PASS      = 4'd7;
  localparam logic [3:0] PH_REQ       = 4'd8;
  localparam logic [3:0] PH_IPV4      = 4'd9;
  localparam logic [3:0] PH_DLEN      = 4'd10;
  localparam logic [3:0] PH_DOMAIN    = 4'd11;
  localparam logic [3:0] PH_PORT      = 4'd12;
  localparam logic [3:0] PH_WAIT      = 4'd13;
  localparam logic [3:0] PH_RELAY     = 4'd14;
  localparam logic [3:0] PH_CLOSED    = 4'd15;

  localparam logic [7:0] SOCKS_VER = 8'h05;
  localparam logic [7:0] SUBNEG_VER = 8'h01;
  localparam logic [7:0] M_USERPASS = 8'h02;
  localparam logic [7:0] M_NONE_OK = 8'hFF;
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] ATYP_IPV4 = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] REP_OK = 8'h00;
  localparam logic [7:0] REP_BACKEND = 8'h05;
  localparam logic [7:0] REP_CMD = 8'h07;
  localparam logic [7:0] REP_ATYP = 8'h08;
  localparam logic [1:0] ACT_JUNK = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] value;
    logic       ok;
  } beat_t;

  // directed row: a beat and, where obvious, the expected reply stream
  typedef struct {
    beat_t      b;
    int         n_exp;
    logic [7:0] exp_bytes[0:3];
    logic [2:0] exp_tail;
  } row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  action = '0;
  logic [7:0]  byte_value = '0;
  logic        backend_ok = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic        target_is_domain;
  logic [31:0] target_ipv4;
  logic [15:0] target_port;
  logic [7:0]  host_length;
  logic        last;

  socks5_server_handshake_parser u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .byte_value_i(byte_value), .backend_ok_i(backend_ok),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .out_byte_o(out_byte), .target_is_domain_o(target_is_domain),
    .target_ipv4_o(target_ipv4), .target_port_o(target_port),
    .host_length_o(host_length), .last_o(last)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state and its copy of the registers
  logic [4:0]  m_user_len, m_pass_len;
  logic [63:0] m_user_lo, m_user_hi, m_pass_lo, m_pass_hi;
  logic [3:0]  phase;
  logic [7:0]  cnt, flen;
  logic        offers, u_ok, p_ok, is_dom;
  logic [31:0] addr;
  logic [15:0] port;

  res_t pending_results[$];
  res_t step_out[$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   beats_sent = 0;

  bit idle_on = 1;

  function automatic res_t mk(logic [2:0] k, logic [7:0] b, logic d,
                              logic [31:0] ip, logic [15:0] p, logic [7:0] hl);
    res_t r;
    r.kind = k; r.out_byte = b; r.dom = d; r.ip = ip; r.port = p; r.hlen = hl;
    r.last = 0;
    return r;
  endfunction

  function automatic void put_reply(logic [7:0] b);
    step_out.insert(step_out.size(), mk(KIND_REPLY, b, 0, 0, 0, 0));
  endfunction

  function automatic void put_close();
    step_out.insert(step_out.size(), mk(KIND_CLOSED, 0, 0, 0, 0, 0));
    phase = PH_CLOSED;
  endfunction

  function automatic void put_long(logic [7:0] code);
    put_reply(SOCKS_VER); put_reply(code); put_reply(8'h00); put_reply(8'h01);
    for (int i = 0; i < 6; i++) put_reply(8'h00);
  endfunction

  function automatic logic cred_match(logic [63:0] lo, logic [63:0] hi,
                                      logic [7:0] idx, logic [7:0] b);
    logic [127:0] w;
    w = {hi, lo};
    if (idx >= 8'(CredBytes)) return 0;
    return w[8*idx[3:0] +: 8] == b;
  endfunction

  function automatic void session_clear();
    phase = PH_GREET_VER; cnt = 0; flen = 0; offers = 0; u_ok = 0; p_ok = 0;
    is_dom = 0; addr = 0; port = 0;
  endfunction

  function automatic void finish_request();
    if (is_dom) step_out.insert(step_out.size(), mk(KIND_DONE, 0, 1, 0, port, flen));
    else step_out.insert(step_out.size(), mk(KIND_DONE, 0, 0, addr, port, 0));
    phase = PH_WAIT;
  endfunction

  function automatic void give_verdict();
    put_reply(SUBNEG_VER);
    if (u_ok && p_ok) begin
      put_reply(8'h00);
      phase = PH_REQ; cnt = 0; addr = 0;
    end else begin
      put_reply(8'h01);
      put_close();
    end
  endfunction

  function automatic void handshake_byte(logic [7:0] b);
    case (phase)
      PH_GREET_VER: begin
        if (b != SOCKS_VER) put_close();
        else phase = PH_GREET_N;
      end
      PH_GREET_N: begin
        flen = b; cnt = 0; offers = 0;
        if (b == 0) begin
          put_reply(SOCKS_VER); put_reply(M_NONE_OK); put_close();
        end else phase = PH_METHODS;
      end
      PH_METHODS: begin
        if (b == M_USERPASS) offers = 1;
        cnt = cnt + 1;
        if (cnt == flen) begin
          put_reply(SOCKS_VER);
          if (!offers) begin
            put_reply(M_NONE_OK); put_close();
          end else begin
            put_reply(M_USERPASS); phase = PH_SUB_VER;
          end
        end
      end
      PH_SUB_VER: begin
        if (b != SUBNEG_VER) put_close();
        else phase = PH_ULEN;
      end
      PH_ULEN: begin
        flen = b; cnt = 0; u_ok = ({3'b0, m_user_len} == b);
        phase = (b == 0) ? PH_PLEN : PH_UNAME;
      end
      PH_UNAME: begin
        if (!cred_match(m_user_lo, m_user_hi, cnt, b)) u_ok = 0;
        cnt = cnt + 1;
        if (cnt == flen) phase = PH_PLEN;
      end
      PH_PLEN: begin
        flen = b; cnt = 0; p_ok = ({3'b0, m_pass_len} == b);
        if (b != 0) phase = PH_PASS;
        else give_verdict();
      end
      PH_PASS: begin
        if (!cred_match(m_pass_lo, m_pass_hi, cnt, b)) p_ok = 0;
        cnt = cnt + 1;
        if (cnt == flen) give_verdict();
      end
      PH_REQ: begin
        if (cnt < 3) begin
          addr = {addr[23:0], b}; cnt = cnt + 1;
        end else if (addr[23:16] != SOCKS_VER || addr[15:8] != CMD_CONNECT) begin
          put_long(REP_CMD); put_close();
        end else begin
          addr = 0; port = 0; cnt = 0;
          if (b == ATYP_IPV4) begin
            is_dom = 0; phase = PH_IPV4;
          end else if (b == ATYP_DOMAIN) begin
            is_dom = 1; phase = PH_DLEN;
          end else begin
            put_long(REP_ATYP); put_close();
          end
        end
      end
      PH_IPV4: begin
        if (cnt < 4) addr = {addr[23:0], b};
        else port = {port[7:0], b};
        cnt = cnt + 1;
        if (cnt == 6) finish_request();
      end
      PH_DLEN: begin
        flen = b; cnt = 0;
        phase = (b == 0) ? PH_PORT : PH_DOMAIN;
      end
      PH_DOMAIN: begin
        step_out.insert(step_out.size(), mk(KIND_HOST, b, 0, 0, 0, 0));
        cnt = cnt + 1;
        if (cnt == flen) begin
          cnt = 0; phase = PH_PORT;
        end
      end
      PH_PORT: begin
        port = {port[7:0], b}; cnt = cnt + 1;
        if (cnt == 2) finish_request();
      end
      PH_RELAY: step_out.insert(step_out.size(), mk(KIND_FWD, b, 0, 0, 0, 0));
      default: ;
    endcase
  endfunction

  function automatic void predict_beat(beat_t bt);
    step_out.delete();
    if (bt.action == ACT_BYTE) handshake_byte(bt.value);
    else if (bt.action == ACT_BACKEND) begin
      if (phase == PH_WAIT) begin
        if (bt.ok) begin
          put_long(REP_OK); phase = PH_RELAY;
        end else begin
          put_long(REP_BACKEND); put_close();
        end
      end
    end else if (bt.action == ACT_NEW) session_clear();
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1;
    foreach (step_out[i]) pending_results.insert(pending_results.size(), step_out[i]);
  endfunction

  // output side: check every accepted result against the oldest expectation
  always @(posedge clk) begin
    res_t got, want;
    if (out_valid && !out_stall) begin
      got = {kind, out_byte, target_is_domain, target_ipv4, target_port,
             host_length, last};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: expected none, got %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // receiver stall in random bursts
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_USER_LEN: m_user_len = v[4:0];
      CFG_USER_LO:  m_user_lo = v;
      CFG_USER_HI:  m_user_hi = v;
      CFG_PASS_LEN: m_pass_len = v[4:0];
      CFG_PASS_LO:  m_pass_lo = v;
      CFG_PASS_HI:  m_pass_hi = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // send one beat, idling in front of it now and then
  task automatic send(beat_t bt);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1; action <= bt.action; byte_value <= bt.value; backend_ok <= bt.ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(bt);
    beats_sent++;
  endtask

  function automatic beat_t cb(logic [7:0] v);
    beat_t b;
    b.action = ACT_BYTE; b.value = v; b.ok = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic beat_t ctl(logic [1:0] a, logic ok);
    beat_t b;
    b.action = a; b.value = 8'($urandom_range(0, 255)); b.ok = ok;
    return b;
  endfunction

  function automatic logic [7:0] user_byte(int i);
    logic [127:0] w;
    w = {m_user_hi, m_user_lo};
    return w[8*i +: 8];
  endfunction

  function automatic logic [7:0] pass_byte(int i);
    logic [127:0] w;
    w = {m_pass_hi, m_pass_lo};
    return w[8*i +: 8];
  endfunction

  // one session, mostly well formed, with a chance of breakage at most steps
  task automatic random_session();
    int nm, ulen, plen, dl;
    bit bad;
    bad = ($urandom_range(0, 4) == 0);
    send(ctl(ACT_NEW, 0));
    send(cb((bad && $urandom_range(0, 3) == 0) ? 8'($urandom) : SOCKS_VER));
    nm = $urandom_range(0, 4);
    send(cb(8'(nm)));
    for (int i = 0; i < nm; i++)
      send(cb((i == nm - 1 && !(bad && $urandom_range(0, 2) == 0)) ? M_USERPASS
              : 8'($urandom)));
    send(cb((bad && $urandom_range(0, 3) == 0) ? 8'($urandom) : SUBNEG_VER));
    ulen = (bad && $urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : m_user_len;
    send(cb(8'(ulen)));
    for (int i = 0; i < ulen; i++)
      send(cb((i < 16 && !(bad && $urandom_range(0, 5) == 0)) ? user_byte(i)
              : 8'($urandom)));
    plen = (bad && $urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : m_pass_len;
    send(cb(8'(plen)));
    for (int i = 0; i < plen; i++)
      send(cb((i < 16 && !(bad && $urandom_range(0, 5) == 0)) ? pass_byte(i)
              : 8'($urandom)));
    send(cb((bad && $urandom_range(0, 4) == 0) ? 8'($urandom) : SOCKS_VER));
    send(cb((bad && $urandom_range(0, 4) == 0) ? 8'($urandom) : CMD_CONNECT));
    send(cb(8'($urandom)));
    if ($urandom_range(0, 1)) begin
      send(cb((bad && $urandom_range(0, 3) == 0) ? 8'($urandom) : ATYP_IPV4));
      repeat (6) send(cb(8'($urandom)));
    end else begin
      send(cb(ATYP_DOMAIN));
      dl = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      send(cb(8'(dl)));
      repeat (dl + 2) send(cb(8'($urandom)));
    end
    if ($urandom_range(0, 5) == 0) send(cb(8'($urandom)));  // ignored while waiting
    send(ctl(ACT_BACKEND, $urandom_range(0, 3) != 0));
    repeat ($urandom_range(0, 5)) send(cb(8'($urandom)));
    if ($urandom_range(0, 7) == 0) send(ctl(ACT_JUNK, 0));
  endtask

  row_t rows[$];

  task automatic add_row(beat_t b, int n, logic [7:0] b0, logic [7:0] b1,
                         logic [2:0] tail);
    row_t r;
    r.b = b; r.n_exp = n; r.exp_bytes = '{b0, b1, 8'h00, 8'h00}; r.exp_tail = tail;
    rows.insert(rows.size(), r);
  endtask

  initial begin
    int sessions;
    session_clear();
    m_user_len = 0; m_pass_len = 0;
    m_user_lo = 0; m_user_hi = 0; m_pass_lo = 0; m_pass_hi = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed part at reset credentials (both empty)
    add_row(cb(8'h04), 1, 8'h00, 8'h00, KIND_CLOSED);          // bad greeting version
    add_row(ctl(ACT_NEW, 0), 0, 0, 0, 0);
    add_row(cb(SOCKS_VER), 0, 0, 0, 0);
    add_row(cb(8'h00), 3, SOCKS_VER, M_NONE_OK, KIND_CLOSED);  // empty method list
    add_row(ctl(ACT_NEW, 0), 0, 0, 0, 0);
    add_row(cb(SOCKS_VER), 0, 0, 0, 0);
    add_row(cb(8'h02), 0, 0, 0, 0);
    add_row(cb(8'hFF), 0, 0, 0, 0);
    add_row(cb(M_USERPASS), 2, SOCKS_VER, M_USERPASS, KIND_REPLY);
    add_row(cb(SUBNEG_VER), 0, 0, 0, 0);
    add_row(cb(8'h00), 0, 0, 0, 0);
    add_row(cb(8'h00), 2, SUBNEG_VER, 8'h00, KIND_REPLY);      // empty credentials pass
    add_row(cb(SOCKS_VER), 0, 0, 0, 0);
    add_row(cb(8'h02), 0, 0, 0, 0);                            // bad command
    add_row(cb(8'h00), 0, 0, 0, 0);
    add_row(cb(ATYP_IPV4), -1, 0, 0, 0);
    add_row(ctl(ACT_BACKEND, 1), -1, 0, 0, 0);                 // outside wait: ignored
    add_row(ctl(ACT_JUNK, 0), -1, 0, 0, 0);
    add_row(cb(8'hFF), -1, 0, 0, 0);                           // after close: ignored
    foreach (rows[i]) begin
      send(rows[i].b);
      if (rows[i].n_exp >= 0) begin
        if (step_out.size() != rows[i].n_exp ||
            (rows[i].n_exp > 0 &&
             step_out[step_out.size()-1].kind != rows[i].exp_tail) ||
            (rows[i].n_exp > 1 &&
             (step_out[0].out_byte != rows[i].exp_bytes[0] ||
              step_out[1].out_byte != rows[i].exp_bytes[1]))) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: expected %0d results ending in kind %0d, got %p",
                     i, rows[i].n_exp, rows[i].exp_tail, step_out);
        end
      end
    end
    drain();

    // credential settings: extremes and random, one batch of sessions each
    sessions = 0;
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: begin
          cfg_write(CFG_USER_LEN, 64'd16); cfg_write(CFG_PASS_LEN, 64'd16);
          cfg_write(CFG_USER_LO, '1); cfg_write(CFG_USER_HI, '1);
          cfg_write(CFG_PASS_LO, '1); cfg_write(CFG_PASS_HI, '1);
        end
        1: begin
          cfg_write(CFG_USER_LEN, 64'd0); cfg_write(CFG_PASS_LEN, 64'd1);
          cfg_write(CFG_PASS_LO, 64'h0); cfg_write(CFG_PASS_HI, 64'h0);
        end
        default: begin
          cfg_write(CFG_USER_LEN, 64'($urandom_range(0, 16)));
          cfg_write(CFG_PASS_LEN, 64'($urandom_range(0, 16)));
          cfg_write(CFG_USER_LO, {$urandom, $urandom});
          cfg_write(CFG_USER_HI, {$urandom, $urandom});
          cfg_write(CFG_PASS_LO, {$urandom, $urandom});
          cfg_write(CFG_PASS_HI, {$urandom, $urandom});
        end
      endcase
      if (s == 4) idle_on = 0;
      while (beats_sent < 30 * (s + 1)) begin
        random_session();
        sessions++;
      end
      drain();  // sender holds off until all results are in
    end

    $display("covered %0d beats over %0d sessions, %0d results checked",
             beats_sent, sessions, results_seen);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_socks5_server_handshake_parser: done, clean");
    else
      $display("tb_socks5_server_handshake_parser: done, errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("tb_socks5_server_handshake_parser: done, errors");
    $finish;
  end

endmodule
